FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is asserted
`define A2I_ASSERT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds during reset
`define A2I_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

FILE: hdl/a2i_pkg.sv
// Types and constants of the 2D affine inverse pipeline.
package a2i_pkg;

	localparam int QBITS = 33;      // quotient bits, one per divider cell
	localparam int NLANE = 4;       // parallel divisions
	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
	localparam logic signed [31:0] ZERO_Q16 = 32'sh0000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// Payload flowing through the divider cells
	typedef struct packed {
		logic [NLANE-1:0][63:0] rem;    // partial remainders
		logic [63:0] den;               // |det|
		logic [NLANE-1:0][QBITS-1:0] quo;
		logic [NLANE-1:0] lsb;          // next bit shifted into remainder
		logic [NLANE-1:0] ovf;          // quotient at least 2^33
		logic [NLANE-1:0] neg;          // result sign
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic zero;                     // determinant is zero
	} div_t;

	// Clamp a 50-bit signed value to 32 bits
	function automatic logic [32:0] clamp50(input logic signed [49:0] v);
		logic [32:0] r;
		if (v > 50'(S32_MAX)) begin
			r = {1'b1, S32_MAX};
		end else if (v < 50'(S32_MIN)) begin
			r = {1'b1, S32_MIN};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

FILE: hdl/affine_2d_inverse.sv
// Top level of the 2D affine transform inverse pipeline.
//
//  channel   direction  signals
//  s_axis    in         tvalid tready tdata(192)
//  m_axis    out        tvalid tready tdata(192) tuser(2)
//
// One transaction per cycle sustained while m_axis is not stalled: 4 front
// stages, 33 divider cells (one quotient bit each), 4 back stages. Each
// stage holds its own valid, so bubbles close up when the output stalls
// and new transactions are taken while a result waits.
// Reset clears all stage valids asynchronously.
module affine_2d_inverse import a2i_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [191:0] s_axis_tdata,  // lin_a, lin_b, lin_c, lin_d, shift_x, shift_y
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [191:0] m_axis_tdata,  // inv_a, inv_b, inv_c, inv_d, inv_shift_x, inv_shift_y
	output logic [1:0]   m_axis_tuser   // singular, saturated
);

	logic [QBITS:0] cv, cr;
	div_t cd [QBITS+1];

	a2i_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.out_valid(cv[0]),
		.out_ready(cr[0]),
		.out_data (cd[0])
	);

	// Divider chain
	for (genvar k = 0; k < QBITS; k++) begin : g_cell
		a2i_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (cv[k]),
			.in_ready (cr[k]),
			.in_data  (cd[k]),
			.out_valid(cv[k+1]),
			.out_ready(cr[k+1]),
			.out_data (cd[k+1])
		);
	end

	a2i_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cv[QBITS]),
		.in_ready (cr[QBITS]),
		.in_data  (cd[QBITS]),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.out_user (m_axis_tuser)
	);

endmodule

FILE: hdl/a2i_front.sv
// Front stages: determinant, magnitudes and divider setup.
module a2i_front import a2i_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [191:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output div_t         out_data
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic signed [31:0] a_in, b_in, c_in, d_in;
	logic signed [63:0] pad_s1, pbc_s1;
	logic signed [31:0] a_s1, b_s1, c_s1, d_s1, tx_s1, ty_s1;

	logic signed [64:0] det_s2;
	logic [NLANE-1:0][31:0] numm_s2, numm_s3;
	logic [NLANE-1:0] numneg_s2, numneg_s3;
	logic signed [31:0] tx_s2, ty_s2, tx_s3, ty_s3;

	logic [63:0] detm_s3;
	logic detneg_s3, zero_s3;
	logic signed [64:0] det_neg;

	div_t d_s4;

	assign a_in = in_data[31:0];
	assign b_in = in_data[63:32];
	assign c_in = in_data[95:64];
	assign d_in = in_data[127:96];

	// Per-stage readiness: a stage loads when empty or draining
	assign rdy4 = !v_s4 || out_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Stage 1: cross products
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			pad_s1 <= 64'(a_in) * 64'(d_in);
			pbc_s1 <= 64'(b_in) * 64'(c_in);
			a_s1 <= a_in;
			b_s1 <= b_in;
			c_s1 <= c_in;
			d_s1 <= d_in;
			tx_s1 <= in_data[159:128];
			ty_s1 <= in_data[191:160];
		end
	end

	// Stage 2: determinant, numerator magnitudes (d, -b, -c, a)
	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			det_s2 <= 65'(pad_s1) - 65'(pbc_s1);
			numm_s2[0] <= d_s1[31] ? 32'(-d_s1) : d_s1;
			numm_s2[1] <= b_s1[31] ? 32'(-b_s1) : b_s1;
			numm_s2[2] <= c_s1[31] ? 32'(-c_s1) : c_s1;
			numm_s2[3] <= a_s1[31] ? 32'(-a_s1) : a_s1;
			numneg_s2[0] <= d_s1[31];
			numneg_s2[1] <= !b_s1[31] && (b_s1 != ZERO_Q16);
			numneg_s2[2] <= !c_s1[31] && (c_s1 != ZERO_Q16);
			numneg_s2[3] <= a_s1[31];
			tx_s2 <= tx_s1;
			ty_s2 <= ty_s1;
		end
	end

	// Stage 3: determinant magnitude
	assign det_neg = -det_s2;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			detm_s3 <= det_s2[64] ? det_neg[63:0] : det_s2[63:0];
			detneg_s3 <= det_s2[64];
			zero_s3 <= (det_s2 == 65'sd0);
			numm_s3 <= numm_s2;
			numneg_s3 <= numneg_s2;
			tx_s3 <= tx_s2;
			ty_s3 <= ty_s2;
		end
	end

	// Stage 4: divider setup, remainder starts at |num| >> 1
	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			for (int i = 0; i < NLANE; i++) begin
				d_s4.rem[i] <= {33'd0, numm_s3[i][31:1]};
				d_s4.lsb[i] <= numm_s3[i][0];
				d_s4.quo[i] <= '0;
				d_s4.ovf[i] <= ({33'd0, numm_s3[i][31:1]} >= detm_s3);
				d_s4.neg[i] <= numneg_s3[i] ^ detneg_s3;
			end
			d_s4.den <= detm_s3;
			d_s4.tx <= tx_s3;
			d_s4.ty <= ty_s3;
			d_s4.zero <= zero_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_data = d_s4;

endmodule

FILE: hdl/a2i_div_cell.sv
// One restoring-division step for all lanes, with its pipeline register.
module a2i_div_cell import a2i_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  div_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output div_t out_data
);

	logic valid_q;
	div_t data_q;
	div_t nxt;
	logic [64:0] r2;
	logic ge;

	assign in_ready = !valid_q || out_ready;

	// Shift in one bit, subtract divisor where it fits
	always_comb begin
		nxt = in_data;
		r2 = '0;
		ge = 1'b0;
		for (int i = 0; i < NLANE; i++) begin
			r2 = {in_data.rem[i], in_data.lsb[i]};
			ge = (r2 >= {1'b0, in_data.den});
			nxt.rem[i] = ge ? 64'(r2 - {1'b0, in_data.den}) : r2[63:0];
			nxt.quo[i] = {in_data.quo[i][QBITS-2:0], ge};
			nxt.lsb[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule

FILE: hdl/a2i_back.sv
// Back stages: quotient saturation, inverse translation, output register.
module a2i_back import a2i_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  div_t         in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [191:0] out_data,
	output logic [1:0]   out_user
);

	logic v_s5, v_s6, v_s7, v_s8;
	logic rdy5, rdy6, rdy7, rdy8;

	logic signed [NLANE-1:0][31:0] ent_s5, ent_s6, ent_s7, ent_s8;
	logic [NLANE-1:0] sat_n;
	logic sat_s5, sat_s6, sat_s7, zero_s5, zero_s6, zero_s7;
	logic signed [31:0] tx_s5, ty_s5;
	logic signed [NLANE-1:0][31:0] ent_n;
	logic signed [63:0] p0_s6, p1_s6, p2_s6, p3_s6;
	logic signed [64:0] sx_s7, sy_s7;
	logic signed [64:0] flx, fly;
	logic [32:0] cx, cy;
	logic signed [31:0] itx_s8, ity_s8;
	logic sing_s8, sat_s8;

	assign rdy8 = !v_s8 || out_ready;
	assign rdy7 = !v_s7 || rdy8;
	assign rdy6 = !v_s6 || rdy7;
	assign rdy5 = !v_s5 || rdy6;
	assign in_ready = rdy5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy5) v_s5 <= in_valid;
			if (rdy6) v_s6 <= v_s5;
			if (rdy7) v_s7 <= v_s6;
			if (rdy8) v_s8 <= v_s7;
		end
	end

	// Signed, saturated linear entries
	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			if (in_data.neg[i]) begin
				sat_n[i] = in_data.ovf[i] || (in_data.quo[i] > 33'h0_8000_0000);
				ent_n[i] = sat_n[i] ? S32_MIN : 32'(-in_data.quo[i]);
			end else begin
				sat_n[i] = in_data.ovf[i] || (in_data.quo[i][32:31] != 2'b00);
				ent_n[i] = sat_n[i] ? S32_MAX : in_data.quo[i][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5 && in_valid) begin
			ent_s5 <= ent_n;
			sat_s5 <= |sat_n;
			zero_s5 <= in_data.zero;
			tx_s5 <= in_data.tx;
			ty_s5 <= in_data.ty;
		end
	end

	// Translation products; packed elements read back unsigned, so sign them
	always_ff @(posedge clk) begin
		if (rdy6 && v_s5) begin
			p0_s6 <= 64'($signed(ent_s5[0])) * 64'(tx_s5);
			p1_s6 <= 64'($signed(ent_s5[1])) * 64'(ty_s5);
			p2_s6 <= 64'($signed(ent_s5[2])) * 64'(tx_s5);
			p3_s6 <= 64'($signed(ent_s5[3])) * 64'(ty_s5);
			ent_s6 <= ent_s5;
			sat_s6 <= sat_s5;
			zero_s6 <= zero_s5;
		end
	end

	// Exact sums
	always_ff @(posedge clk) begin
		if (rdy7 && v_s6) begin
			sx_s7 <= 65'(p0_s6) + 65'(p1_s6);
			sy_s7 <= 65'(p2_s6) + 65'(p3_s6);
			ent_s7 <= ent_s6;
			sat_s7 <= sat_s6;
			zero_s7 <= zero_s6;
		end
	end

	// Floor by 2^16, negate, clamp; singular gives identity
	assign flx = sx_s7 >>> 16;
	assign fly = sy_s7 >>> 16;
	assign cx = clamp50(-(50'($signed(flx[48:0]))));
	assign cy = clamp50(-(50'($signed(fly[48:0]))));

	always_ff @(posedge clk) begin
		if (rdy8 && v_s7) begin
			if (zero_s7) begin
				ent_s8[0] <= ONE_Q16;
				ent_s8[1] <= ZERO_Q16;
				ent_s8[2] <= ZERO_Q16;
				ent_s8[3] <= ONE_Q16;
				itx_s8 <= ZERO_Q16;
				ity_s8 <= ZERO_Q16;
				sat_s8 <= 1'b0;
			end else begin
				ent_s8 <= ent_s7;
				itx_s8 <= cx[31:0];
				ity_s8 <= cy[31:0];
				sat_s8 <= sat_s7 || cx[32] || cy[32];
			end
			sing_s8 <= zero_s7;
		end
	end

	assign out_valid = v_s8;
	assign out_data = {ity_s8, itx_s8, ent_s8[3], ent_s8[2], ent_s8[1], ent_s8[0]};
	assign out_user = {sat_s8, sing_s8};

endmodule

FILE: hdl/a2i_checker.sv
// Port-level checks for the affine inverse, bound to the top level.
`include "assert_macros.svh"

module a2i_checker import a2i_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [191:0] s_axis_tdata,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [191:0] m_axis_tdata,
	input logic [1:0]   m_axis_tuser
);

	logic         out_sing, sing_ident, out_stall, in_stall;
	logic [194:0] out_word;
	logic [192:0] in_word;

	assign out_sing = m_axis_tvalid && m_axis_tuser[0];
	assign sing_ident = (m_axis_tdata == {64'd0, ONE_Q16, 64'd0, ONE_Q16}) && !m_axis_tuser[1];
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign out_word = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};
	assign in_stall = s_axis_tvalid && !s_axis_tready;
	assign in_word = {s_axis_tvalid, s_axis_tdata};

	// Singular result is the identity and never flagged saturated
	`A2I_ASSERT(a_sing_ident, clk, arst_n, out_sing |-> sing_ident, "singular result is not identity")

	// Stalled result holds
	`A2I_ASSERT(a_out_hold, clk, arst_n, out_stall |=> $stable(out_word), "stalled result changed")

	// Stalled input transaction holds
	`A2I_ASSERT(a_in_hold, clk, arst_n, in_stall |=> $stable(in_word), "stalled input changed")

	// No result while in reset
	`A2I_ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind affine_2d_inverse a2i_checker u_a2i_checker (.*);
